FILE: sv/fmmrs_pkg.sv
// Shared types and constants for the frame min/max/rms statistics block.
package fmmrs_pkg;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_MEAN,
    ST_SQRT,
    ST_OUT
  } state_t;

  // The square root resolves one result bit per step.
  localparam int STEPS  = 16;
  localparam int STEP_W = 4;

  // Field widths of the stream payloads.
  localparam int CODE_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 7;
  localparam int RMS_W    = 15;
  localparam int FID_W    = 32;
  localparam int SQ_W     = 31;
  localparam int ROOT_W   = 32;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 112;

  // The mean square is taken in units of 2^15, and the rms operand is the saturated mean
  // shifted back up by the same amount.
  localparam int MEAN_SHIFT = 15;

endpackage

FILE: sv/fmmrs_csub.sv
// Shared compare-and-subtract unit used by the square root steps.
module fmmrs_csub #(
  parameter int W = 48
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] wide;

  // The borrow out of the extended subtraction tells whether a is below b.
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[W-1:0];
  assign ge   = ~wide[W];

endmodule

FILE: sv/frame_min_max_rms_stats.sv
// Top level of the frame min/max/rms statistics block.
// An accepted item passes through ST_MUL and ST_ACC to ST_OUT, where its result is
// registered; the item that closes a frame first passes ST_MEAN and 16 square root steps.
// The sequencer, with its single compare-and-subtract unit, takes no new item until it
// is back in ST_IDLE, and a held result blocks the next item.
// Reset (rst_n low, synchronous) clears the sequencer, statistics, frame counter,
// quant_mode and the output valid flag.
module frame_min_max_rms_stats #(
  parameter int FRAME_LEN = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration: bit 0 is quant_mode.
  input  logic                                 cfg_we,
  input  logic                                 cfg_wdata,
  // Input stream. tdata: adc_code [9:0], zero fill [15:10].
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fmmrs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result stream. tdata: sample_q15 [15:0], max_value [31:16], max_index [38:32],
  // min_value [54:39], min_index [61:55], rms_value [76:62], frame_id [108:77],
  // zero fill [111:109]. tlast is frame_last.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fmmrs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tlast
);

  // The square sum must hold FRAME_LEN squares of at most 2^30 each.
  localparam int SUM_W = fmmrs_pkg::SQ_W + $clog2(FRAME_LEN);
  // The mean square is floor(floor(sum / 2^15) / FRAME_LEN). The division by the frame
  // length is a multiply by the rounded-up reciprocal and a shift, which is exact for
  // every numerator of MEAN_NUM_W bits.
  localparam int MEAN_NUM_W = SUM_W - fmmrs_pkg::MEAN_SHIFT;
  localparam int LOG_FL     = $clog2(FRAME_LEN);
  localparam int RECIP_W    = MEAN_NUM_W + 1;
  localparam int PROD_W     = MEAN_NUM_W + RECIP_W;
  localparam int QUOT_LSB   = MEAN_NUM_W + LOG_FL;
  localparam longint unsigned RECIP_FULL =
    ((longint'(1) << QUOT_LSB) + longint'(FRAME_LEN) - 1) / longint'(FRAME_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  // Sample counter is at least as wide as the reported positions.
  localparam int CNT_W = ($clog2(FRAME_LEN) > fmmrs_pkg::POS_W) ?
                         $clog2(FRAME_LEN) : fmmrs_pkg::POS_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN - 1);
  localparam logic [fmmrs_pkg::ROOT_W-1:0] BIT_INIT = fmmrs_pkg::ROOT_W'(1) << 30;
  localparam logic [fmmrs_pkg::STEP_W-1:0] LAST_STEP =
    fmmrs_pkg::STEP_W'(fmmrs_pkg::STEPS - 1);

  fmmrs_pkg::state_t state_r, state_nxt;

  logic                                  quant_mode_r;
  logic signed [fmmrs_pkg::SAMPLE_W-1:0] s_r;
  logic signed [fmmrs_pkg::SAMPLE_W-1:0] s_in;
  logic [fmmrs_pkg::SQ_W-1:0]            sq_r;
  logic signed [2*fmmrs_pkg::SAMPLE_W-1:0] sq_full;
  logic [CNT_W-1:0]                      count_r;
  logic                                  last_r;
  logic signed [fmmrs_pkg::SAMPLE_W-1:0] max_r, min_r;
  logic [fmmrs_pkg::POS_W-1:0]           max_pos_r, min_pos_r;
  logic [SUM_W-1:0]                      sum_r;
  logic [SUM_W-1:0]                      frame_sum;
  logic [fmmrs_pkg::FID_W-1:0]           frame_cnt_r;
  logic [fmmrs_pkg::FID_W-1:0]           fid_next;
  logic [fmmrs_pkg::STEP_W-1:0]          step_r;
  logic [MEAN_NUM_W-1:0]                 mean_num_r;
  logic [PROD_W-1:0]                     mean_prod;
  logic [fmmrs_pkg::RMS_W:0]             mean_q;
  logic [fmmrs_pkg::ROOT_W-1:0]          x_r, root_r, bit_r, trial;
  logic [fmmrs_pkg::RMS_W-1:0]           mean_sat;

  logic [fmmrs_pkg::ROOT_W-1:0] cs_diff;
  logic                         cs_ge;

  logic                                  out_valid_r;
  logic [fmmrs_pkg::OUT_TDATA_W-1:0]     out_data_r;
  logic                                  out_last_r;

  logic in_acc;
  logic out_free;
  logic out_load;

  // Centering and scaling reduce to flipping the code's top bit and placing it in q15:
  // fine mode keeps all ten bits, coarse mode keeps the top four.
  always_comb begin
    if (quant_mode_r) begin
      s_in = {~in_tdata[9], in_tdata[8:6], 12'd0};
    end else begin
      s_in = {~in_tdata[9], in_tdata[8:0], 6'd0};
    end
  end

  assign sq_full   = s_r * s_r;
  assign frame_sum = sum_r + SUM_W'(sq_r);
  assign fid_next  = frame_cnt_r + fmmrs_pkg::FID_W'(1);
  assign trial     = root_r + bit_r;

  // Mean square of the frame, saturated to the 15-bit rms operand range.
  assign mean_prod = mean_num_r * RECIP;
  assign mean_q    = mean_prod[QUOT_LSB +: fmmrs_pkg::RMS_W + 1];
  assign mean_sat  = mean_q[fmmrs_pkg::RMS_W] ? {fmmrs_pkg::RMS_W{1'b1}} :
                     mean_q[fmmrs_pkg::RMS_W-1:0];

  // The one compare-and-subtract unit, stepped through the square root.
  fmmrs_csub #(.W(fmmrs_pkg::ROOT_W)) u_csub (
    .a    (x_r),
    .b    (trial),
    .diff (cs_diff),
    .ge   (cs_ge)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fmmrs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = fmmrs_pkg::ST_MUL;
        end
      end
      fmmrs_pkg::ST_MUL: state_nxt = fmmrs_pkg::ST_ACC;
      fmmrs_pkg::ST_ACC: begin
        state_nxt = last_r ? fmmrs_pkg::ST_MEAN : fmmrs_pkg::ST_OUT;
      end
      fmmrs_pkg::ST_MEAN: state_nxt = fmmrs_pkg::ST_SQRT;
      fmmrs_pkg::ST_SQRT: begin
        if (step_r == LAST_STEP) begin
          state_nxt = fmmrs_pkg::ST_OUT;
        end
      end
      fmmrs_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = fmmrs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fmmrs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  assign out_free = ~out_valid_r | out_tready;
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      fmmrs_pkg::ST_IDLE: in_tready = 1'b1;
      fmmrs_pkg::ST_OUT:  out_load  = out_free;
      default: begin
        in_tready = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  assign in_acc = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmmrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_mode_r <= 1'b0;
    end else if (cfg_we) begin
      quant_mode_r <= cfg_wdata;
    end
  end

  // Item registers and squaring.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_r <= s_in;
    end
    if (state_r == fmmrs_pkg::ST_MUL) begin
      sq_r <= sq_full[fmmrs_pkg::SQ_W-1:0];
    end
  end

  // Running statistics. The first sample of a frame loads both extremes; ties keep
  // the earlier position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      last_r      <= 1'b0;
      max_r       <= '0;
      min_r       <= '0;
      max_pos_r   <= '0;
      min_pos_r   <= '0;
      sum_r       <= '0;
      frame_cnt_r <= '0;
    end else begin
      if (state_r == fmmrs_pkg::ST_MUL) begin
        last_r <= (count_r == LAST_CNT);
        if (count_r == '0) begin
          max_r     <= s_r;
          min_r     <= s_r;
          max_pos_r <= '0;
          min_pos_r <= '0;
        end else begin
          if (s_r > max_r) begin
            max_r     <= s_r;
            max_pos_r <= count_r[fmmrs_pkg::POS_W-1:0];
          end
          if (s_r < min_r) begin
            min_r     <= s_r;
            min_pos_r <= count_r[fmmrs_pkg::POS_W-1:0];
          end
        end
      end
      if (state_r == fmmrs_pkg::ST_ACC) begin
        sum_r   <= frame_sum;
        count_r <= count_r + 1'b1;
      end
      if (out_load && last_r) begin
        count_r     <= '0;
        max_r       <= '0;
        min_r       <= '0;
        max_pos_r   <= '0;
        min_pos_r   <= '0;
        sum_r       <= '0;
        frame_cnt_r <= fid_next;
      end
    end
  end

  // Square root step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (state_r == fmmrs_pkg::ST_SQRT) begin
      step_r <= step_r + 1'b1;
    end else begin
      step_r <= '0;
    end
  end

  // Mean and square root datapath. The root starts from its top bit every time; the
  // leading steps simply leave a small operand untouched.
  always_ff @(posedge clk) begin
    case (state_r)
      fmmrs_pkg::ST_ACC: begin
        mean_num_r <= frame_sum[SUM_W-1:fmmrs_pkg::MEAN_SHIFT];
      end
      fmmrs_pkg::ST_MEAN: begin
        x_r    <= fmmrs_pkg::ROOT_W'(mean_sat) << fmmrs_pkg::MEAN_SHIFT;
        root_r <= '0;
        bit_r  <= BIT_INIT;
      end
      fmmrs_pkg::ST_SQRT: begin
        if (cs_ge) begin
          x_r    <= cs_diff;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: begin
      end
    endcase
  end

  // Output register: it holds a finished result while the next item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_last_r <= last_r;
      out_data_r <= last_r ?
        {3'b000, fid_next, root_r[fmmrs_pkg::RMS_W-1:0], min_pos_r, min_r,
         max_pos_r, max_r, s_r} :
        {{(fmmrs_pkg::OUT_TDATA_W - fmmrs_pkg::SAMPLE_W){1'b0}}, s_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Items are taken only by an idle sequencer.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> state_r == fmmrs_pkg::ST_IDLE)
    else $error("item accepted while sequencer busy");

  // A frame-closing result leaves the statistics cleared for the next frame.
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_r |=> count_r == '0 && sum_r == '0)
    else $error("statistics not cleared after frame end");

  // Ordinary items carry no statistics.
  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[108:16] == '0)
    else $error("statistics fields set on a non-final item");

  // The square root phase always starts from step zero.
  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fmmrs_pkg::ST_MEAN |=> state_r == fmmrs_pkg::ST_SQRT && step_r == '0)
    else $error("square root step counter not reset");

  // A frame end passes through exactly sixteen square root steps before output.
  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fmmrs_pkg::ST_SQRT && step_r == LAST_STEP |=>
    state_r == fmmrs_pkg::ST_OUT)
    else $error("square root phase length wrong");

endmodule

FILE: tb/tb_frame_min_max_rms_stats.sv
// Testbench for the frame min/max/rms statistics block: stream stimulus and self-checking.
module tb_frame_min_max_rms_stats;

  // The block under test keeps its default frame length, so frames close every 128 items
  // and the reported positions cover their whole range.
  localparam int FRAME_LEN   = 128;
  localparam int CYCLE_LIMIT = 200000;
  // The tail wait outlasts the longest path through the block, the one at a frame end,
  // so that a stray extra result would still be seen.
  localparam int TAIL_CYCLES = 48;
  // Long output hold-off used to fill the block up and stall its input.
  localparam int HOLD_CYCLES = 400;

  // Values of the quant_mode register.
  localparam bit MODE_FINE   = 1'b0;
  localparam bit MODE_COARSE = 1'b1;

  // Content profiles of the random frames.
  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_NARROW,
    SHAPE_FLAT,
    SHAPE_RAILS,
    SHAPE_LEVELS
  } frame_shape_t;

  // One result item, holding the fields of the result stream and its tlast flag.
  typedef struct packed {
    logic [fmmrs_pkg::SAMPLE_W-1:0] sample;
    logic                           last;
    logic [fmmrs_pkg::SAMPLE_W-1:0] max_value;
    logic [fmmrs_pkg::POS_W-1:0]    max_index;
    logic [fmmrs_pkg::SAMPLE_W-1:0] min_value;
    logic [fmmrs_pkg::POS_W-1:0]    min_index;
    logic [fmmrs_pkg::RMS_W-1:0]    rms;
    logic [fmmrs_pkg::FID_W-1:0]    frame_id;
  } frame_stats_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              cfg_we     = 1'b0;
  logic                              cfg_wdata  = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [fmmrs_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [fmmrs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tlast;

  // Results the block still owes, oldest first.
  frame_stats_t stats_due[$];

  // Our own copy of the block's statistics state and its register.
  bit              quant_mode_q = MODE_FINE;
  int              fill         = 0;
  int              hi_val       = 0;
  int              hi_pos       = 0;
  int              lo_val       = 0;
  int              lo_pos       = 0;
  longint unsigned sq_acc       = 0;
  logic [fmmrs_pkg::FID_W-1:0] frames_done = '0;

  // Idle and stall rates in percent, and the receiver's hold-off request.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  int field_errors = 0;
  int cycle_count  = 0;

  frame_min_max_rms_stats #(
    .FRAME_LEN (FRAME_LEN)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Global watchdog: a run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("frame_min_max_rms_stats verification failed");
      $finish;
    end
  end

  // Floor of the square root, found one result bit at a time from the top.
  function automatic int unsigned floor_root(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= x) root = trial;
    end
    return int'(root);
  endfunction

  // Folds one accepted converter code into the statistics and queues the result it causes.
  task automatic fold_code(input logic [fmmrs_pkg::CODE_W-1:0] code);
    frame_stats_t    r;
    int              s;
    longint unsigned mean;
    longint unsigned sat_mean;
    int unsigned     root;
    // Coarse mode keeps only the top four code bits, so the centring is done in that domain,
    // which floors negative values toward minus infinity as required.
    if (quant_mode_q == MODE_COARSE) s = (int'(code[9:6]) - 8) * 4096;
    else s = (int'(code) - 512) * 64;

    // The first sample of a frame seeds both extremes at position zero.  Later samples
    // only replace an extreme when strictly beyond it, so ties keep the first position.
    if (fill == 0) begin
      hi_val = s;
      hi_pos = 0;
      lo_val = s;
      lo_pos = 0;
      sq_acc = 0;
    end else begin
      if (s > hi_val) begin
        hi_val = s;
        hi_pos = fill;
      end
      if (s < lo_val) begin
        lo_val = s;
        lo_pos = fill;
      end
    end
    sq_acc += longint'(s) * longint'(s);
    fill++;

    r = '0;
    r.sample = s[fmmrs_pkg::SAMPLE_W-1:0];
    if (fill >= FRAME_LEN) begin
      mean     = (sq_acc / FRAME_LEN) >> 15;
      sat_mean = (mean > 32767) ? 32767 : mean;
      root     = floor_root(sat_mean << 15);
      if (root > 32767) root = 32767;
      frames_done = frames_done + 1'b1;
      r.last      = 1'b1;
      r.max_value = hi_val[fmmrs_pkg::SAMPLE_W-1:0];
      r.max_index = fmmrs_pkg::POS_W'(hi_pos % 128);
      r.min_value = lo_val[fmmrs_pkg::SAMPLE_W-1:0];
      r.min_index = fmmrs_pkg::POS_W'(lo_pos % 128);
      r.rms       = root[fmmrs_pkg::RMS_W-1:0];
      r.frame_id  = frames_done;
      fill   = 0;
      hi_val = 0;
      hi_pos = 0;
      lo_val = 0;
      lo_pos = 0;
      sq_acc = 0;
    end
    stats_due.push_back(r);
  endtask

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    field_errors++;
    if (field_errors <= 10)
      $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
               what, cycle_count, want, got);
  endfunction

  // Receiver side.  A hold-off request takes priority and is counted down here, one cycle
  // per falling edge; otherwise tready follows the current stall rate.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checker: every accepted result item is matched against the oldest one owed.
  always @(posedge clk) begin : result_check
    frame_stats_t want;
    frame_stats_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.sample    = out_tdata[15:0];
      got.max_value = out_tdata[31:16];
      got.max_index = out_tdata[38:32];
      got.min_value = out_tdata[54:39];
      got.min_index = out_tdata[61:55];
      got.rms       = out_tdata[76:62];
      got.frame_id  = out_tdata[108:77];
      got.last      = out_tlast;
      if (stats_due.size() == 0) begin
        note_mismatch("unrequested result, sample", '0, 32'(got.sample));
      end else begin
        want = stats_due.pop_front();
        if (got.sample !== want.sample)
          note_mismatch("sample_q15", 32'(want.sample), 32'(got.sample));
        if (got.last !== want.last)
          note_mismatch("frame_last", 32'(want.last), 32'(got.last));
        if (got.max_value !== want.max_value)
          note_mismatch("max_value", 32'(want.max_value), 32'(got.max_value));
        if (got.max_index !== want.max_index)
          note_mismatch("max_index", 32'(want.max_index), 32'(got.max_index));
        if (got.min_value !== want.min_value)
          note_mismatch("min_value", 32'(want.min_value), 32'(got.min_value));
        if (got.min_index !== want.min_index)
          note_mismatch("min_index", 32'(want.min_index), 32'(got.min_index));
        if (got.rms !== want.rms)
          note_mismatch("rms_value", 32'(want.rms), 32'(got.rms));
        if (got.frame_id !== want.frame_id)
          note_mismatch("frame_id", want.frame_id, got.frame_id);
      end
    end
  end

  // Offers one converter code, idling first at the current rate.  Valid is left high after
  // the handshake so that back-to-back items need no extra edge; the next call or the
  // settle task decides what it does at the following falling edge.
  task automatic send_code(input logic [fmmrs_pkg::CODE_W-1:0] code);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= fmmrs_pkg::IN_TDATA_W'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(fmmrs_pkg::IN_TDATA_W - fmmrs_pkg::CODE_W){1'b0}}, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_code(code);
  endtask

  // Stops offering items and waits until every owed result has been taken.
  task automatic settle_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block drained.  Every item yields a result, so an
  // empty queue means the block is idle.
  task automatic write_quant_mode(input bit mode);
    settle_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    quant_mode_q = mode;
  endtask

  // Full precision: converter rails, midscale and its neighbours, and repeated rails so that
  // ties with the running extremes come up early in the frame.
  task automatic test_fine_scaling();
    logic [fmmrs_pkg::CODE_W-1:0] codes[$];
    codes = {10'd512, 10'd0, 10'd1023, 10'd511, 10'd513, 10'd0, 10'd1023,
             10'd1, 10'd1022, 10'd682, 10'd341};
    write_quant_mode(MODE_FINE);
    foreach (codes[i]) send_code(codes[i]);
  endtask

  // Four-bit requantisation: both sides of every boundary around midscale and the rails,
  // where negative values must round down rather than toward zero.
  task automatic test_coarse_scaling();
    logic [fmmrs_pkg::CODE_W-1:0] codes[$];
    codes = {10'd0, 10'd63, 10'd64, 10'd511, 10'd512, 10'd575, 10'd576,
             10'd1023, 10'd960, 10'd959, 10'd448, 10'd447};
    write_quant_mode(MODE_COARSE);
    foreach (codes[i]) send_code(codes[i]);
  endtask

  // Random frames with varied content.  Each chunk of a frame's length draws a profile and
  // a register setting, so frames see mode changes, flat runs full of ties, rail-to-rail
  // swings and narrow bands that give a wide spread of rms values.
  task automatic test_random_frames(input int items, input int send_pct, input int recv_pct);
    frame_shape_t shape;
    int           center;
    int           spread;
    int           v;
    int           n;
    int           k;
    int           level[4];
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    n = 0;
    while (n < items) begin
      write_quant_mode($urandom_range(0, 1) ? MODE_COARSE : MODE_FINE);
      shape  = frame_shape_t'($urandom_range(SHAPE_UNIFORM, SHAPE_LEVELS));
      center = $urandom_range(0, 1023);
      spread = $urandom_range(0, 40);
      foreach (level[i]) level[i] = $urandom_range(0, 1023);
      k = 0;
      while (k < FRAME_LEN && n < items) begin
        case (shape)
          SHAPE_UNIFORM: v = $urandom_range(0, 1023);
          SHAPE_NARROW: begin
            v = center + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
          end
          SHAPE_FLAT: v = center;
          SHAPE_RAILS: begin
            if ($urandom_range(0, 1)) v = 1023 - int'($urandom_range(0, 3));
            else v = $urandom_range(0, 3);
          end
          default: v = level[$urandom_range(0, 3)];
        endcase
        send_code(v[fmmrs_pkg::CODE_W-1:0]);
        k++;
        n++;
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items
  // without gaps, so the block fills up and has to drop in_tready.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    repeat (40) send_code(fmmrs_pkg::CODE_W'($urandom_range(0, 1023)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fine_scaling();
    test_coarse_scaling();
    test_random_frames(300, 35, 79);
    test_random_frames(300, 79, 35);
    test_random_frames(300, 0, 0);
    test_output_backpressure();

    settle_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (field_errors == 0 && stats_due.size() == 0) begin
      $display("frame_min_max_rms_stats verification clean");
    end else begin
      $display("frame_min_max_rms_stats verification failed");
    end
    $finish;
  end

endmodule
